FILE: sv/pcg32_pkg.sv
// Shared types, constants and output permutation for the PCG32 generator.
// No dependencies; used by pcg32_ctrl, pcg32_dp and the top level.
`default_nettype none

package pcg32_pkg;

    localparam int STATE_W = 64;
    localparam int HALF_W  = 32;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 6;

    localparam logic [STATE_W-1:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] PCG_INC  = 64'd1442695040888963407;
    localparam logic [STATE_W-1:0] PCG_INIT = 64'hcafef00dd15ea5e5;

    // Configuration register indexes
    localparam logic CFG_VARIANT = 1'b0;
    localparam logic CFG_SEED    = 1'b1;

    // Divider step count (one quotient bit per cycle)
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(VALUE_W);

    typedef struct packed {
        logic load_item;   // capture bound, draw; start divider
        logic mul_lo;      // low x low partial product
        logic mul_x1;      // high x low cross term
        logic mul_x2;      // low x high cross term
        logic mul_sum;     // fold last cross term
        logic state_upd;   // write back new state
        logic load_out;    // fill output register
    } pcg_cmd_t;

    typedef struct packed {
        logic seed_write;
        logic div_done;
        logic out_free;
    } pcg_status_t;

    // Output permutation applied to the state before it advances.
    function automatic logic [VALUE_W-1:0] pcg_draw(input logic [STATE_W-1:0] s,
                                                    input logic variant);
        logic [STATE_W-1:0] t;
        logic [5:0]         sh;
        logic [4:0]         rot;
        logic [VALUE_W-1:0] x;
        logic [STATE_W-1:0] shifted;
        if (variant)
        begin
            rot = s[63:59];
            t   = s ^ (s >> 18);
            x   = t[58:27];
            pcg_draw = (x >> rot) | (x << ((6'd32 - {1'b0, rot}) & 6'd31));
        end
        else
        begin
            sh      = 6'd22 + {3'b000, s[63:61]};
            t       = s ^ (s >> 22);
            shifted = t >> sh;
            pcg_draw = shifted[VALUE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/pcg32_ctrl.sv
// Sequencer for the PCG32 generator: accept or reseed, split multiply, wait on divider, output.
// Depends on pcg32_pkg.
`default_nettype none

module pcg32_ctrl
    import pcg32_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  pcg_status_t status,
    output pcg_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MUL_LO   = 8'b0000_0010,
        S_MUL_X1   = 8'b0000_0100,
        S_MUL_X2   = 8'b0000_1000,
        S_MUL_SUM  = 8'b0001_0000,
        S_UPD      = 8'b0010_0000,
        S_DIV_WAIT = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        seeding_reg, seeding_next;

    always_comb
    begin
        state_next   = state_reg;
        seeding_next = seeding_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !status.seed_write;
                if (status.seed_write)
                begin
                    seeding_next = 1'b1;
                    state_next   = S_MUL_LO;
                end
                else if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    seeding_next  = 1'b0;
                    state_next    = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_X1;
            end
            S_MUL_X1:
            begin
                cmd.mul_x1 = 1'b1;
                state_next = S_MUL_X2;
            end
            S_MUL_X2:
            begin
                cmd.mul_x2 = 1'b1;
                state_next = S_MUL_SUM;
            end
            S_MUL_SUM:
            begin
                cmd.mul_sum = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                cmd.state_upd = 1'b1;
                state_next    = seeding_reg ? S_IDLE : S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            seeding_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seeding_reg <= seeding_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pcg32_dp.sv
// Datapath for the PCG32 generator: state, shared 32x32 multiplier, restoring
// remainder unit, config registers and output register. Depends on pcg32_pkg.
`default_nettype none

module pcg32_dp
    import pcg32_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_write_en,
    input  wire                cfg_index,
    input  wire  [STATE_W-1:0] cfg_data,
    input  wire  [VALUE_W-1:0] bound,
    input  wire                out_ready,
    output logic               out_valid,
    output logic [VALUE_W-1:0] random_value,
    input  pcg_cmd_t           cmd,
    output pcg_status_t        status
);

    logic [STATE_W-1:0] gen_state_reg;
    logic               variant_reg;
    logic [STATE_W-1:0] prod_reg;
    logic [STATE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] bound_reg;
    logic [VALUE_W-1:0] draw_reg;
    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] dividend_reg;
    logic [CNT_W-1:0]   div_cnt_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic               seed_write;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [VALUE_W:0]   trial;
    logic               trial_ge;

    assign seed_write = cfg_write_en && (cfg_index == CFG_SEED);

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = gen_state_reg[HALF_W-1:0];
        mul_b = PCG_MULT[HALF_W-1:0];
        if (cmd.mul_x1)
            mul_a = gen_state_reg[STATE_W-1:HALF_W];
        if (cmd.mul_x2)
            mul_b = PCG_MULT[STATE_W-1:HALF_W];
    end

    assign trial    = {rem_reg, dividend_reg[VALUE_W-1]};
    assign trial_ge = trial >= {1'b0, bound_reg};

    // Configuration and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= PCG_INIT;
            variant_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en && (cfg_index == CFG_VARIANT))
                variant_reg <= cfg_data[0];
            if (seed_write)
                gen_state_reg <= {cfg_data[STATE_W-2:0], 1'b1};
            else if (cmd.state_upd)
                gen_state_reg <= acc_reg + (variant_reg ? PCG_INC : '0);
        end
    end

    // Multiply: low 64 bits of state * multiplier from three partial products
    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo || cmd.mul_x1 || cmd.mul_x2)
            prod_reg <= STATE_W'(mul_a) * STATE_W'(mul_b);
        if (cmd.mul_x1)
            acc_reg <= prod_reg;
        else if (cmd.mul_x2 || cmd.mul_sum)
            acc_reg[STATE_W-1:HALF_W] <= acc_reg[STATE_W-1:HALF_W] + prod_reg[HALF_W-1:0];
    end

    // Item capture and restoring remainder, one bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            bound_reg    <= bound;
            draw_reg     <= pcg_draw(gen_state_reg, variant_reg);
            dividend_reg <= pcg_draw(gen_state_reg, variant_reg);
            rem_reg      <= '0;
        end
        else if (div_cnt_reg != DIV_STEPS)
        begin
            rem_reg      <= trial_ge ? VALUE_W'(trial - {1'b0, bound_reg})
                                     : trial[VALUE_W-1:0];
            dividend_reg <= {dividend_reg[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= DIV_STEPS;
        else if (cmd.load_item)
            div_cnt_reg <= '0;
        else if (div_cnt_reg != DIV_STEPS)
            div_cnt_reg <= div_cnt_reg + 1'b1;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_value_reg <= (bound_reg == '0) ? draw_reg : rem_reg;
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_value_reg;

    assign status.seed_write = seed_write;
    assign status.div_done   = (div_cnt_reg == DIV_STEPS);
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

FILE: sv/pcg32_random_generator.sv
// Top level of the PCG32 random generator: sequencer plus datapath.
// Depends on pcg32_pkg, pcg32_ctrl and pcg32_dp.
//
// Usage:
//   Input channel (in_valid/in_ready/bound): one transfer requests one value.
//   Output channel (out_valid/out_ready/random_value): one transfer per request,
//   in request order. random_value is the draw modulo bound, or the raw draw
//   when bound is zero.
//   Config port: cfg_write_en with cfg_index 0 sets the variant (0 = MCG with
//   shift output, 1 = LCG with XSH-RR); index 1 reseeds the state to
//   2*seed+1 and advances it once (in_ready low meanwhile).
//   Write config only while the block is idle.
// Sequence:
//   Items are handled one at a time; throughput is set by the one-bit-per-cycle
//   remainder unit (32 steps). The 64-bit state multiply runs on one shared
//   32x32 multiplier (low product, two cross terms, fold, then write-back),
//   overlapped with the remainder. in_ready returns the cycle after the result
//   enters the output register.
// Reset: state = 0xcafef00dd15ea5e5, variant 0, no result pending.
// Stall: the result waits in the output register; a finished item holds in
//   its result state until that register is free, so nothing is dropped.
`default_nettype none

module pcg32_random_generator
    import pcg32_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    // configuration write port
    input  wire                cfg_write_en,
    input  wire                cfg_index,
    input  wire  [STATE_W-1:0] cfg_data,
    // request channel
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [VALUE_W-1:0] bound,
    // result channel
    output logic               out_valid,
    input  wire                out_ready,
    output logic [VALUE_W-1:0] random_value
);

    pcg_cmd_t    cmd;
    pcg_status_t status;

    pcg32_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pcg32_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .bound        (bound),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .random_value (random_value),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for pcg32_random_generator: random requests, reseeds, variant switches.
// Depends on pcg32_pkg (widths, register indexes, generator constants) and the top level.
module testbench;
    import pcg32_pkg::*;

    // Overall cycle budget; the slowest legal run stays well within it.
    localparam int CYCLE_LIMIT   = 1000000;
    // Quiet cycles before a register write and at the end.
    localparam int SETTLE_CYCLES = 40;
    // Random traffic: phases of requests, each under its own register setting.
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 115;

    // Tracks generator state and holds the values still owed by the block.
    class draw_scoreboard;
        logic [STATE_W-1:0] gen_state;
        logic               variant;
        logic [VALUE_W-1:0] owed_values[$];
        int                 error_count;

        function new();
            gen_state   = PCG_INIT;
            variant     = 1'b0;
            error_count = 0;
        endfunction

        // Output permutation of the current state, then advance it.
        function logic [VALUE_W-1:0] next_draw();
            logic [STATE_W-1:0] s;
            logic [STATE_W-1:0] t;
            logic [VALUE_W-1:0] x;
            int unsigned        rot;
            s = gen_state;
            if (variant)
            begin
                // LCG step, XSH-RR output
                rot       = s[63:59];
                gen_state = s * PCG_MULT + PCG_INC;
                t         = s ^ (s >> 18);
                x         = t[58:27];
                next_draw = (x >> rot) | (x << ((32 - rot) & 31));
            end
            else
            begin
                // MCG step, xorshift then shift by 22 plus the top three bits
                gen_state = s * PCG_MULT;
                t         = s ^ (s >> 22);
                t         = t >> (22 + s[63:61]);
                next_draw = t[VALUE_W-1:0];
            end
        endfunction

        function void write_register(logic idx, logic [STATE_W-1:0] data);
            logic [VALUE_W-1:0] discard;
            if (idx == CFG_VARIANT)
            begin
                variant = data[0];
            end
            else
            begin
                // 2*seed+1 wraps mod 2^64; the first draw is thrown away
                gen_state = (data << 1) | 64'd1;
                discard   = next_draw();
            end
        endfunction

        function void note_request(logic [VALUE_W-1:0] limit);
            logic [VALUE_W-1:0] v;
            v = next_draw();
            if (limit != 0)
                v = v % limit;
            owed_values.push_back(v);
        endfunction

        function void check_value(logic [VALUE_W-1:0] actual);
            logic [VALUE_W-1:0] want;
            if (owed_values.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, actual);
                error_count++;
            end
            else
            begin
                want = owed_values.pop_front();
                if (actual !== want)
                begin
                    $display("%0t: random_value mismatch, expected %h, actual %h",
                             $time, want, actual);
                    error_count++;
                end
            end
        endfunction

        function int owed_count();
            return owed_values.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic               cfg_index;
    logic [STATE_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] bound;
    logic               out_valid;
    logic               out_ready;
    logic [VALUE_W-1:0] random_value;

    draw_scoreboard     sb;
    bit                 idle_on;     // random bursts of idling enabled on both sides
    int                 stall_left;  // remaining cycles of the current receive stall
    int                 cycle_count;

    pcg32_random_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .bound        (bound),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_value (random_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: check every transfer against the oldest owed value, then pick
    // out_ready for the next cycle. A stall starts at random while idling is on.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_value(random_value);
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // One request transfer, optionally preceded by a short idle burst.
    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_request(input logic [VALUE_W-1:0] limit);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        bound    <= limit;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(limit);
    endtask

    // Stop sending and wait until every owed value has been returned.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.owed_count() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the block idle. A short quiet time on both
    // sides of the write lets the reseed sequence take over in_ready.
    task automatic write_cfg(input logic idx, input logic [STATE_W-1:0] data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        sb.write_register(idx, data);
        cfg_write_en <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // Variant write with random upper data bits; only bit 0 matters.
    task automatic set_variant(input logic v);
        logic [STATE_W-1:0] data;
        data    = {$urandom, $urandom};
        data[0] = v;
        write_cfg(CFG_VARIANT, data);
    endtask

    function automatic logic [VALUE_W-1:0] pick_bound();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return $urandom_range(1, 16);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            3:       return 32'h1 << $urandom_range(0, 31);
            4:       return $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [STATE_W-1:0] pick_seed();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_VARIANT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        bound        = '0;
        out_ready    = 1'b0;
        idle_on      = 1'b1;
        stall_left   = 0;
        cycle_count  = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state under the MCG variant, bound extremes.
        send_request(32'h0);
        send_request(32'hFFFF_FFFF);
        send_request(32'h1);
        send_request(32'h2);
        send_request(32'h8000_0000);
        send_request(32'hFFFF_FFFE);
        send_request(32'h3);

        // Switch to LCG without reseeding.
        set_variant(1'b1);
        send_request(32'h0);
        send_request(32'h1);
        send_request(32'hFFFF_FFFF);
        send_request(32'd10);

        // Seed zero, then all ones (2*seed+1 wraps).
        write_cfg(CFG_SEED, '0);
        send_request(32'h0);
        send_request(32'h0);
        write_cfg(CFG_SEED, '1);
        send_request(32'h0);
        send_request(32'd7);

        // Back to the MCG variant from whatever (possibly even) state LCG left.
        set_variant(1'b0);
        send_request(32'h0);
        send_request(32'd5);

        // Top seed bit set: state wraps to 1 before the discarded draw.
        write_cfg(CFG_SEED, 64'h8000_0000_0000_0000);
        send_request(32'h0);
        send_request(32'h0);
        write_cfg(CFG_SEED, '1);
        send_request(32'h0);
        send_request(32'd100);
        set_variant(1'b1);
        send_request(32'h0);

        // Random phases; every fourth phase and the last two run without idling.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                set_variant(1'b0);
            else if (phase == 1)
                set_variant(1'b1);
            else
                set_variant($urandom_range(0, 1));
            if ($urandom_range(0, 2) != 0)
                write_cfg(CFG_SEED, pick_seed());
            idle_on = (phase % 4 != 3) && (phase < PHASES - 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // once mid-run, hold off until the block has returned everything
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_request(pick_bound());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
